// File: hdl/qtp_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the quintic trajectory point pipeline.
// No dependencies; qtp_poly, the top level and qtp_check refer to this package by scoped names.
package qtp_pkg;

    localparam int FRAC_W     = 30;   // fraction bits of tau and its powers
    localparam int TICK_W     = 31;   // move duration register
    localparam int TIME_W     = 32;   // time field
    localparam int RATE_W     = 48;   // velocity and acceleration fields
    localparam int U_W        = FRAC_W + 1;  // tau in [0, 1] as Q.30
    localparam int POLY_W     = 40;   // signed width of the polynomial sums
    localparam int RATE_SHIFT = 14;   // 30 fraction bits down to 16
    localparam int NUM1_W     = TICK_W + FRAC_W;
    localparam int VDIV_W     = TICK_W + RATE_SHIFT;
    localparam int ADIV_W     = 2 * TICK_W + RATE_SHIFT;
    localparam int POW_STAGES = 6;    // four powers, polynomial sums, magnitudes
    localparam int LATENCY    = 1 + U_W + POW_STAGES + 1 + RATE_W + 1;

    // Polynomial coefficients.
    localparam int C_S3 = 10;
    localparam int C_S4 = 15;
    localparam int C_S5 = 6;
    localparam int C_G2 = 30;
    localparam int C_G3 = 60;
    localparam int C_G4 = 30;
    localparam int C_H1 = 60;
    localparam int C_H2 = 180;
    localparam int C_H3 = 120;

    localparam logic [U_W-1:0] U_ONE = U_W'(1) << FRAC_W;
    localparam logic [RATE_W-1:0] RATE_POS_MAX = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic [RATE_W-1:0] RATE_NEG_MAX = {1'b1, {(RATE_W-1){1'b0}}};

    // Register index carried by paddr[2].
    localparam logic REG_MOVE_TICKS = 1'b0;

    typedef enum logic [2:0] {
        MODE_PRE  = 3'b001,
        MODE_RUN  = 3'b010,
        MODE_POST = 3'b100
    } mode_t;

endpackage

// File: hdl/qtp_div_pipe.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Depends on nothing; flags quotients that do not fit in QW bits.
module qtp_div_pipe #(
    parameter int NW = 61,
    parameter int DW = 31,
    parameter int QW = 31,
    parameter int PW = 1
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] n_in,
    input  logic [DW-1:0] d_in,
    input  logic [PW-1:0] pay_in,
    output logic [QW-1:0] q_out,
    output logic          ovf_out,
    output logic [PW-1:0] pay_out
);

    localparam int XW = (NW > QW + DW) ? NW : QW + DW;
    localparam int HW = XW - QW;

    logic [XW-1:0] nx;
    logic [HW-1:0] hi;
    logic [HW-1:0] dx;
    logic          ovf0;

    assign nx   = XW'(n_in);
    assign hi   = nx[XW-1:QW];
    assign dx   = HW'(d_in);
    // If the top part already reaches the divisor, the quotient needs more than QW bits.
    assign ovf0 = (hi >= dx);

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] lo_reg  [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [PW-1:0] pay_reg [QW];
    logic          ovf_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_c;
        logic [QW-1:0] lo_c;
        logic [QW-1:0] q_c;
        logic [PW-1:0] pay_c;
        logic          ovf_c;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_c = hi[DW-1:0];
            assign lo_c  = nx[QW-1:0];
            assign q_c   = '0;
            assign pay_c = pay_in;
            assign ovf_c = ovf0;
        end else begin : g_next
            assign rem_c = rem_reg[k-1];
            assign lo_c  = lo_reg[k-1];
            assign q_c   = q_reg[k-1];
            assign pay_c = pay_reg[k-1];
            assign ovf_c = ovf_reg[k-1];
        end

        assign trial = {rem_c, lo_c[QW-1]};
        assign diff  = trial - {1'b0, d_in};
        assign ge    = (trial >= {1'b0, d_in});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                lo_reg[k]  <= lo_c << 1;
                q_reg[k]   <= {q_c[QW-2:0], ge};
                pay_reg[k] <= pay_c;
                ovf_reg[k] <= ovf_c;
            end
        end
    end

    assign q_out   = q_reg[QW-1];
    assign ovf_out = ovf_reg[QW-1];
    assign pay_out = pay_reg[QW-1];

endmodule

// File: hdl/qtp_poly.sv
`timescale 1ns / 1ps
// Powers of tau, the three quintic polynomials and their magnitudes, six stages.
// Depends on qtp_pkg.
module qtp_poly #(
    parameter int PW = 1
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [qtp_pkg::U_W-1:0]    u1_in,
    input  logic [PW-1:0]              pay_in,
    output logic [qtp_pkg::U_W-1:0]    s_out,
    output logic [qtp_pkg::POLY_W-1:0] g_mag_out,
    output logic                       g_neg_out,
    output logic [qtp_pkg::POLY_W-1:0] h_mag_out,
    output logic                       h_neg_out,
    output logic [PW-1:0]              pay_out
);

    localparam int UW = qtp_pkg::U_W;
    localparam int FW = qtp_pkg::FRAC_W;
    localparam int LW = qtp_pkg::POLY_W;

    logic [UW-1:0] p1_u1_reg, p1_u2_reg;
    logic [UW-1:0] p2_u1_reg, p2_u2_reg, p2_u3_reg;
    logic [UW-1:0] p3_u1_reg, p3_u2_reg, p3_u3_reg, p3_u4_reg;
    logic [UW-1:0] p4_u1_reg, p4_u2_reg, p4_u3_reg, p4_u4_reg, p4_u5_reg;
    logic [PW-1:0] p1_pay_reg, p2_pay_reg, p3_pay_reg, p4_pay_reg, p5_pay_reg, p6_pay_reg;

    logic [2*UW-1:0] m1, m2, m3, m4;

    // Each power is truncated back to Q.30 before the next multiply.
    assign m1 = (2*UW)'(u1_in) * (2*UW)'(u1_in);
    assign m2 = (2*UW)'(p1_u2_reg) * (2*UW)'(p1_u1_reg);
    assign m3 = (2*UW)'(p2_u3_reg) * (2*UW)'(p2_u1_reg);
    assign m4 = (2*UW)'(p3_u4_reg) * (2*UW)'(p3_u1_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_u1_reg  <= u1_in;
            p1_u2_reg  <= m1[FW +: UW];
            p1_pay_reg <= pay_in;

            p2_u1_reg  <= p1_u1_reg;
            p2_u2_reg  <= p1_u2_reg;
            p2_u3_reg  <= m2[FW +: UW];
            p2_pay_reg <= p1_pay_reg;

            p3_u1_reg  <= p2_u1_reg;
            p3_u2_reg  <= p2_u2_reg;
            p3_u3_reg  <= p2_u3_reg;
            p3_u4_reg  <= m3[FW +: UW];
            p3_pay_reg <= p2_pay_reg;

            p4_u1_reg  <= p3_u1_reg;
            p4_u2_reg  <= p3_u2_reg;
            p4_u3_reg  <= p3_u3_reg;
            p4_u4_reg  <= p3_u4_reg;
            p4_u5_reg  <= m4[FW +: UW];
            p4_pay_reg <= p3_pay_reg;
        end
    end

    logic signed [LW-1:0] x1, x2, x3, x4, x5;
    logic signed [LW-1:0] s_c, g_c, h_c;
    logic [UW-1:0]        s_clamp;

    assign x1 = signed'(LW'(p4_u1_reg));
    assign x2 = signed'(LW'(p4_u2_reg));
    assign x3 = signed'(LW'(p4_u3_reg));
    assign x4 = signed'(LW'(p4_u4_reg));
    assign x5 = signed'(LW'(p4_u5_reg));

    assign s_c = LW'(qtp_pkg::C_S3) * x3 - LW'(qtp_pkg::C_S4) * x4
               + LW'(qtp_pkg::C_S5) * x5;
    assign g_c = LW'(qtp_pkg::C_G2) * x2 - LW'(qtp_pkg::C_G3) * x3
               + LW'(qtp_pkg::C_G4) * x4;
    assign h_c = LW'(qtp_pkg::C_H1) * x1 - LW'(qtp_pkg::C_H2) * x2
               + LW'(qtp_pkg::C_H3) * x3;

    always_comb begin
        if (s_c < 0) begin
            s_clamp = '0;
        end else if (s_c > signed'(LW'(qtp_pkg::U_ONE))) begin
            s_clamp = qtp_pkg::U_ONE;
        end else begin
            s_clamp = s_c[UW-1:0];
        end
    end

    logic [UW-1:0]        p5_s_reg, p6_s_reg;
    logic signed [LW-1:0] p5_g_reg, p5_h_reg;
    logic [LW-1:0]        p6_gm_reg, p6_hm_reg;
    logic                 p6_gn_reg, p6_hn_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p5_s_reg   <= s_clamp;
            p5_g_reg   <= g_c;
            p5_h_reg   <= h_c;
            p5_pay_reg <= p4_pay_reg;

            p6_s_reg   <= p5_s_reg;
            p6_gm_reg  <= p5_g_reg[LW-1] ? LW'(-p5_g_reg) : LW'(p5_g_reg);
            p6_gn_reg  <= p5_g_reg[LW-1];
            p6_hm_reg  <= p5_h_reg[LW-1] ? LW'(-p5_h_reg) : LW'(p5_h_reg);
            p6_hn_reg  <= p5_h_reg[LW-1];
            p6_pay_reg <= p5_pay_reg;
        end
    end

    assign s_out     = p6_s_reg;
    assign g_mag_out = p6_gm_reg;
    assign g_neg_out = p6_gn_reg;
    assign h_mag_out = p6_hm_reg;
    assign h_neg_out = p6_hn_reg;
    assign pay_out   = p6_pay_reg;

endmodule

// File: hdl/quintic_trajectory_point.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; a stall on the result side holds every stage.
// Depth comes mostly from the 31-stage tau divider and the 48-stage rate dividers.
// Reset (aresetn low, synchronous) empties the pipeline and sets move_ticks to 1.
// Depends on qtp_pkg, qtp_div_pipe and qtp_poly.
module quintic_trajectory_point #(
    parameter int POS_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // time_tick, start_pos, target_pos from bit 0 up; zero padding on top
    input  logic [((qtp_pkg::TIME_W + 2*POS_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // position, velocity, acceleration from bit 0 up; zero padding on top
    output logic [((POS_WIDTH + 2*qtp_pkg::RATE_W + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PS  = POS_WIDTH;
    localparam int DWD = POS_WIDTH + 1;
    localparam int TW  = qtp_pkg::TICK_W;
    localparam int RW  = qtp_pkg::RATE_W;
    localparam int LW  = qtp_pkg::POLY_W;
    localparam int UW  = qtp_pkg::U_W;
    localparam int FW  = qtp_pkg::FRAC_W;
    localparam int LAT = qtp_pkg::LATENCY;
    localparam int IN_W  = ((qtp_pkg::TIME_W + 2*POS_WIDTH + 7) / 8) * 8;
    localparam int OUT_W = ((POS_WIDTH + 2*RW + 7) / 8) * 8;
    localparam int PV_W  = DWD + LW;
    localparam int PA_W  = DWD + LW;
    localparam int MW  = (DWD > RW) ? DWD : RW;

    // ---------------- configuration ----------------
    logic [TW-1:0]   ticks_reg;
    logic [2*TW-1:0] tsq_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= TW'(1);
        end else if (cfg_wr && paddr[2] == qtp_pkg::REG_MOVE_TICKS) begin
            ticks_reg <= (pwdata[TW-1:0] == '0) ? TW'(1) : pwdata[TW-1:0];
        end
    end

    // Square changes after write; user must keep pipeline empty; not enforced.
    always_ff @(posedge aclk) begin
        tsq_reg <= (2*TW)'(ticks_reg) * (2*TW)'(ticks_reg);
    end

    assign prdata = (paddr[2] == qtp_pkg::REG_MOVE_TICKS) ? 32'(ticks_reg) : 32'd0;

    // ---------------- flow control ----------------
    logic [LAT-1:0] vld_reg;
    logic           en;

    assign m_tvalid = vld_reg[LAT-1];
    assign en       = ~m_tvalid | m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid & s_tready};
        end
    end

    // ---------------- input stage ----------------
    logic signed [qtp_pkg::TIME_W-1:0] in_t;
    logic signed [PS-1:0]              in_p0, in_pt;
    qtp_pkg::mode_t                    in_mode;

    assign in_t  = s_tdata[qtp_pkg::TIME_W-1:0];
    assign in_p0 = s_tdata[qtp_pkg::TIME_W +: PS];
    assign in_pt = s_tdata[qtp_pkg::TIME_W + PS +: PS];

    always_comb begin
        if (in_t[qtp_pkg::TIME_W-1]) begin
            in_mode = qtp_pkg::MODE_PRE;
        end else if (in_t > signed'(qtp_pkg::TIME_W'(ticks_reg))) begin
            in_mode = qtp_pkg::MODE_POST;
        end else begin
            in_mode = qtp_pkg::MODE_RUN;
        end
    end

    logic [TW-1:0]   s1_t_reg;
    logic [PS-1:0]   s1_p0_reg, s1_pt_reg;
    logic [DWD-1:0]  s1_d_reg;
    qtp_pkg::mode_t  s1_mode_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            // Outside the move tau is not needed; feed zero to the divider.
            s1_t_reg    <= (in_mode == qtp_pkg::MODE_RUN) ? in_t[TW-1:0] : '0;
            s1_p0_reg   <= in_p0;
            s1_pt_reg   <= in_pt;
            s1_d_reg    <= DWD'(signed'({in_pt[PS-1], in_pt}) - signed'({in_p0[PS-1], in_p0}));
            s1_mode_reg <= in_mode;
        end
    end

    // ---------------- tau = t * 2^30 / T ----------------
    localparam int P1_W = 2*PS + DWD + 3;

    logic [qtp_pkg::NUM1_W-1:0] num1;
    logic [UW-1:0]              u1;
    logic [P1_W-1:0]            d1_pay_in, d1_pay_out;
    logic                       d1_ovf;

    assign num1      = qtp_pkg::NUM1_W'(s1_t_reg) << FW;
    assign d1_pay_in = {s1_p0_reg, s1_pt_reg, s1_d_reg, s1_mode_reg};

    qtp_div_pipe #(
        .NW (qtp_pkg::NUM1_W),
        .DW (TW),
        .QW (UW),
        .PW (P1_W)
    ) u_tau_div (
        .aclk    (aclk),
        .en      (en),
        .n_in    (num1),
        .d_in    (ticks_reg),
        .pay_in  (d1_pay_in),
        .q_out   (u1),
        .ovf_out (d1_ovf),
        .pay_out (d1_pay_out)
    );

    // ---------------- powers and polynomials ----------------
    localparam int P2_W = 2*PS + 3 + 1 + DWD;

    logic [PS-1:0]   t1_p0, t1_pt;
    logic [DWD-1:0]  t1_d, t1_dmag;
    logic [2:0]      t1_mode;
    logic [P2_W-1:0] pw_pay_in, pw_pay_out;

    assign {t1_p0, t1_pt, t1_d, t1_mode} = d1_pay_out;
    assign t1_dmag   = t1_d[DWD-1] ? DWD'(-signed'(t1_d)) : t1_d;
    assign pw_pay_in = {t1_p0, t1_pt, t1_mode, t1_d[DWD-1] & ~d1_ovf, t1_dmag};

    logic [UW-1:0] pw_s;
    logic [LW-1:0] pw_gm, pw_hm;
    logic          pw_gn, pw_hn;

    qtp_poly #(
        .PW (P2_W)
    ) u_poly (
        .aclk      (aclk),
        .en        (en),
        .u1_in     (u1),
        .pay_in    (pw_pay_in),
        .s_out     (pw_s),
        .g_mag_out (pw_gm),
        .g_neg_out (pw_gn),
        .h_mag_out (pw_hm),
        .h_neg_out (pw_hn),
        .pay_out   (pw_pay_out)
    );

    // ---------------- products ----------------
    logic [PS-1:0]  t2_p0, t2_pt;
    logic [2:0]     t2_mode;
    logic           t2_negd;
    logic [DWD-1:0] t2_dmag;

    assign {t2_p0, t2_pt, t2_mode, t2_negd, t2_dmag} = pw_pay_out;

    logic [DWD+UW-1:0] pr_ps_reg;
    logic [PV_W-1:0]   pr_pg_reg;
    logic [PA_W-1:0]   pr_ph_reg;
    logic [PS-1:0]     pr_p0_reg, pr_pt_reg;
    logic [2:0]        pr_mode_reg;
    logic              pr_negd_reg, pr_negv_reg, pr_nega_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_ps_reg   <= (DWD+UW)'(t2_dmag) * (DWD+UW)'(pw_s);
            pr_pg_reg   <= PV_W'(t2_dmag) * PV_W'(pw_gm);
            pr_ph_reg   <= PA_W'(t2_dmag) * PA_W'(pw_hm);
            pr_p0_reg   <= t2_p0;
            pr_pt_reg   <= t2_pt;
            pr_mode_reg <= t2_mode;
            pr_negd_reg <= t2_negd;
            pr_negv_reg <= t2_negd ^ pw_gn;
            pr_nega_reg <= t2_negd ^ pw_hn;
        end
    end

    // ---------------- rate dividers ----------------
    localparam int P3_W = 2*PS + 3 + 1 + 1 + DWD;

    logic [DWD+UW-1:0]      ps_round;
    logic [DWD-1:0]         pos_mag;
    logic [P3_W-1:0]        v_pay_in, v_pay_out;
    logic [0:0]             a_pay_in, a_pay_out;
    logic [qtp_pkg::VDIV_W-1:0] vdiv;
    logic [qtp_pkg::ADIV_W-1:0] adiv;
    logic [RW-1:0]          vq, aq;
    logic                   vovf, aovf;

    // Position magnitude, rounded half away from zero.
    assign ps_round = pr_ps_reg + ((DWD+UW)'(1) << (FW - 1));
    assign pos_mag  = ps_round[FW +: DWD];
    assign v_pay_in = {pr_p0_reg, pr_pt_reg, pr_mode_reg, pr_negd_reg, pr_negv_reg, pos_mag};
    assign a_pay_in = pr_nega_reg;
    assign vdiv     = {ticks_reg, {qtp_pkg::RATE_SHIFT{1'b0}}};
    assign adiv     = {tsq_reg, {qtp_pkg::RATE_SHIFT{1'b0}}};

    qtp_div_pipe #(
        .NW (PV_W),
        .DW (qtp_pkg::VDIV_W),
        .QW (RW),
        .PW (P3_W)
    ) u_vel_div (
        .aclk    (aclk),
        .en      (en),
        .n_in    (pr_pg_reg),
        .d_in    (vdiv),
        .pay_in  (v_pay_in),
        .q_out   (vq),
        .ovf_out (vovf),
        .pay_out (v_pay_out)
    );

    qtp_div_pipe #(
        .NW (PA_W),
        .DW (qtp_pkg::ADIV_W),
        .QW (RW),
        .PW (1)
    ) u_acc_div (
        .aclk    (aclk),
        .en      (en),
        .n_in    (pr_ph_reg),
        .d_in    (adiv),
        .pay_in  (a_pay_in),
        .q_out   (aq),
        .ovf_out (aovf),
        .pay_out (a_pay_out)
    );

    // ---------------- saturation and output word ----------------
    logic [PS-1:0]  f_p0, f_pt;
    logic [2:0]     f_mode;
    logic           f_negd, f_negv;
    logic [DWD-1:0] f_pmag;

    assign {f_p0, f_pt, f_mode, f_negd, f_negv, f_pmag} = v_pay_out;

    logic [RW-1:0] v_lim, a_lim, v_mag, a_mag, v_val, a_val;
    logic [MW-1:0] p_lim, p_ext, p_mag, p_delta;
    logic [PS-1:0] pos_val;

    always_comb begin
        v_lim   = f_negv ? qtp_pkg::RATE_NEG_MAX : qtp_pkg::RATE_POS_MAX;
        a_lim   = a_pay_out[0] ? qtp_pkg::RATE_NEG_MAX : qtp_pkg::RATE_POS_MAX;
        v_mag   = (vovf || vq > v_lim) ? v_lim : vq;
        a_mag   = (aovf || aq > a_lim) ? a_lim : aq;
        v_val   = f_negv ? RW'(-v_mag) : v_mag;
        a_val   = a_pay_out[0] ? RW'(-a_mag) : a_mag;
        p_lim   = MW'(f_negd ? qtp_pkg::RATE_NEG_MAX : qtp_pkg::RATE_POS_MAX);
        p_ext   = MW'(f_pmag);
        p_mag   = (p_ext > p_lim) ? p_lim : p_ext;
        p_delta = f_negd ? MW'(-p_mag) : p_mag;
        case (f_mode)
            qtp_pkg::MODE_RUN: begin
                pos_val = f_p0 + p_delta[PS-1:0];
            end
            qtp_pkg::MODE_POST: begin
                pos_val = f_pt;
                v_val   = '0;
                a_val   = '0;
            end
            default: begin
                pos_val = f_p0;
                v_val   = '0;
                a_val   = '0;
            end
        endcase
    end

    logic [OUT_W-1:0] out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= OUT_W'({a_val, v_val, pos_val});
        end
    end

    assign m_tdata = out_reg;

endmodule

// File: hdl/qtp_check.sv
`timescale 1ns / 1ps
// Port-level checks for quintic_trajectory_point, attached with a bind.
// Depends on qtp_pkg and the top level's port list.
module qtp_check #(
    parameter int POS_WIDTH = 32
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [((qtp_pkg::TIME_W + 2*POS_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [((POS_WIDTH + 2*qtp_pkg::RATE_W + 7) / 8) * 8 - 1:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A held result word stays put until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // With no result waiting, the input side must take words.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // The move duration never reads back as zero.
    a_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        paddr[2] == qtp_pkg::REG_MOVE_TICKS |-> prdata[qtp_pkg::TICK_W-1:0] != '0)
        else $error("move_ticks reads zero");

endmodule

bind quintic_trajectory_point qtp_check #(.POS_WIDTH(POS_WIDTH)) u_qtp_check (.*);
